// ===== sv/ncp_pkg.sv =====
// Shared types and constants of the nearest-color quantizer.
package ncp_pkg;

   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned ColorWidth = 3 * ChanWidth;
   localparam int unsigned IdxWidth   = 8;
   localparam int unsigned NumEntries = 256;
   localparam int unsigned BaseCount  = 16;
   localparam int unsigned CubeSide   = 6;
   localparam int unsigned CubeStep   = 51;
   localparam int unsigned CubeCount  = CubeSide * CubeSide * CubeSide;
   localparam int unsigned GrayStart  = BaseCount + CubeCount;
   localparam int unsigned GrayFull   = 255;
   localparam int unsigned GrayDiv    = 25;
   localparam int unsigned NumRegs    = 6;
   localparam int unsigned RegWidth   = 64;
   localparam int unsigned RegIdxWidth = 3;
   localparam int unsigned DistWidth  = 10;
   localparam int unsigned MaxDist    = 3 * 255;
   localparam logic [DistWidth-1:0] DistInit = '1;

   typedef struct packed {
      logic                   valid;
      logic [ChanWidth-1:0]   red;
      logic [ChanWidth-1:0]   green;
      logic [ChanWidth-1:0]   blue;
      logic [DistWidth-1:0]   best_dist;
      logic [IdxWidth-1:0]    best_idx;
   } stage_type;

endpackage

// ===== sv/ncp_req_if.sv =====
// Pixel input channel: valid/ready handshake with three 8-bit color channels.
interface ncp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ncp_pkg::ChanWidth-1:0] red;
   logic [ncp_pkg::ChanWidth-1:0] green;
   logic [ncp_pkg::ChanWidth-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/ncp_rsp_if.sv =====
// Result channel: valid/ready handshake carrying the palette index.
interface ncp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ncp_pkg::IdxWidth-1:0] palette_index;

   modport source (output valid, output palette_index, input ready);
   modport sink (input valid, input palette_index, output ready);
endinterface

// ===== sv/ncp_cell.sv =====
// One chain cell: compares the passing pixel against one palette entry.
module ncp_cell #(
   parameter logic [ncp_pkg::IdxWidth-1:0] Index = '0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [ncp_pkg::ColorWidth-1:0]  entry_color,
   input  ncp_pkg::stage_type              stage_i,
   output ncp_pkg::stage_type              stage_o
);

   localparam int unsigned CW = ncp_pkg::ChanWidth;
   localparam int unsigned DW = ncp_pkg::DistWidth;

   ncp_pkg::stage_type stage_in;
   ncp_pkg::stage_type stage_ff;
   logic [CW-1:0] diff_r;
   logic [CW-1:0] diff_g;
   logic [CW-1:0] diff_b;
   logic [DW-1:0] dist_sum;
   logic [CW-1:0] ent_r;
   logic [CW-1:0] ent_g;
   logic [CW-1:0] ent_b;

   assign ent_r = entry_color[3*CW-1:2*CW];
   assign ent_g = entry_color[2*CW-1:CW];
   assign ent_b = entry_color[CW-1:0];

   always_comb begin
      diff_r = (stage_i.red   > ent_r) ? stage_i.red   - ent_r : ent_r - stage_i.red;
      diff_g = (stage_i.green > ent_g) ? stage_i.green - ent_g : ent_g - stage_i.green;
      diff_b = (stage_i.blue  > ent_b) ? stage_i.blue  - ent_b : ent_b - stage_i.blue;
      dist_sum = DW'(diff_r) + DW'(diff_g) + DW'(diff_b);
      stage_in = stage_i;
      if (dist_sum < stage_i.best_dist) begin
         stage_in.best_dist = dist_sum;
         stage_in.best_idx  = Index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ===== sv/nearest_color_256_palette_top.sv =====
// Top level of the nearest-color quantizer onto a 256-entry palette.
// Usage: pixels enter on req_chan (red, green, blue), one per clock when
// req_chan.ready is high. Each pixel passes through a chain of 256 cells,
// one per palette entry in index order; every cell keeps the smaller L1
// distance and its index, so ties go to the lowest index.
// Each cell is a register stage; the last cell's register is the output.
// Throughput: one item per cycle while the receiver does not stall.
// When the receiver stalls, the whole chain holds and req_chan.ready drops;
// it is ready again in the cycle the waiting result is taken.
// Configuration: csr_we writes csr_wdata to base-color register csr_index
// (0..5, others ignored); write only while no item is in flight.
// Entries 0..15 come from those registers, 16..231 are the 6x6x6 cube,
// 232..255 the gray ramp.
// Reset: synchronous, clears the chain's valid bits and the base colors
// to black. There is no clearing pass; the block is ready right after reset.
module nearest_color_256_palette_top (
   input  logic                              clock,
   input  logic                              reset,
   ncp_req_if.sink                           req_chan,
   ncp_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [ncp_pkg::RegIdxWidth-1:0]   csr_index,
   input  logic [ncp_pkg::RegWidth-1:0]      csr_wdata
);

   localparam int unsigned N  = ncp_pkg::NumEntries;
   localparam int unsigned CW = ncp_pkg::ChanWidth;
   localparam int unsigned CS = ncp_pkg::CubeSide;

   logic [ncp_pkg::RegWidth-1:0] base_ff [ncp_pkg::NumRegs];
   logic [ncp_pkg::NumRegs*ncp_pkg::RegWidth-1:0] base_flat;
   ncp_pkg::stage_type pipe [N+1];
   logic advance;

   genvar gi;

   generate
      for (gi = 0; gi < ncp_pkg::NumRegs; gi++) begin : g_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               base_ff[gi] <= '0;
            end else if (csr_we && csr_index == ncp_pkg::RegIdxWidth'(gi)) begin
               base_ff[gi] <= csr_wdata;
            end
         end
         assign base_flat[gi*ncp_pkg::RegWidth +: ncp_pkg::RegWidth] = base_ff[gi];
      end
   endgenerate

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      pipe[0].valid     = req_chan.valid;
      pipe[0].red       = req_chan.red;
      pipe[0].green     = req_chan.green;
      pipe[0].blue      = req_chan.blue;
      pipe[0].best_dist = ncp_pkg::DistInit;
      pipe[0].best_idx  = '0;
   end

   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         logic [ncp_pkg::ColorWidth-1:0] color;
         if (gi < ncp_pkg::BaseCount) begin : g_base
            assign color = {base_flat[(3*gi)*CW +: CW],
                            base_flat[(3*gi+1)*CW +: CW],
                            base_flat[(3*gi+2)*CW +: CW]};
         end else if (gi < ncp_pkg::GrayStart) begin : g_cube
            localparam int unsigned Pos  = gi - ncp_pkg::BaseCount;
            localparam int unsigned LvlR = (Pos / (CS * CS)) * ncp_pkg::CubeStep;
            localparam int unsigned LvlG = ((Pos / CS) % CS) * ncp_pkg::CubeStep;
            localparam int unsigned LvlB = (Pos % CS) * ncp_pkg::CubeStep;
            assign color = {CW'(LvlR), CW'(LvlG), CW'(LvlB)};
         end else begin : g_gray
            localparam int unsigned Lvl =
               ((gi - ncp_pkg::GrayStart + 1) * ncp_pkg::GrayFull) / ncp_pkg::GrayDiv;
            assign color = {3{CW'(Lvl)}};
         end
         ncp_cell #(
            .Index(ncp_pkg::IdxWidth'(gi))
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .entry_color(color),
            .stage_i    (pipe[gi]),
            .stage_o    (pipe[gi+1])
         );
      end
   endgenerate

   assign rsp_chan.valid         = pipe[N].valid;
   assign rsp_chan.palette_index = pipe[N].best_idx;

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      pipe[N].valid |-> pipe[N].best_dist <= ncp_pkg::DistWidth'(ncp_pkg::MaxDist))
      else $error("result distance out of range");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> pipe[1].valid)
      else $error("accepted item missing from first cell");

   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pipe[N/2].valid) && $stable(pipe[N/2].best_idx))
      else $error("chain moved during stall");

   a_dist_mono: assert property (@(posedge clock) disable iff (reset)
      (advance && pipe[N-1].valid) |=> pipe[N].best_dist <= $past(pipe[N-1].best_dist))
      else $error("best distance grew along the chain");

endmodule

// ===== test/nearest_color_256_palette_top_tb.sv =====
// Testbench for the nearest-color quantizer: random and directed pixels, scoreboard check.
module nearest_color_256_palette_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ChanWidth   = ncp_pkg::ChanWidth;
   localparam int unsigned IdxWidth    = ncp_pkg::IdxWidth;
   localparam int unsigned RegWidth    = ncp_pkg::RegWidth;
   localparam int unsigned RegIdxWidth = ncp_pkg::RegIdxWidth;
   localparam int unsigned NumRegs     = ncp_pkg::NumRegs;
   localparam int unsigned NumEntries  = ncp_pkg::NumEntries;
   localparam int unsigned BaseCount   = ncp_pkg::BaseCount;
   localparam int unsigned GrayStart   = ncp_pkg::GrayStart;

   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned HOLD_CYCLES   = 700;
   localparam int unsigned SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_pixel_type;

   typedef enum logic [RegIdxWidth-1:0] {
      BASE_REG_0, BASE_REG_1, BASE_REG_2, BASE_REG_3, BASE_REG_4, BASE_REG_5,
      SPARE_REG_6, SPARE_REG_7
   } base_reg_type;

   typedef logic [RegWidth-1:0] base_table_type [NumRegs];

   localparam rgb_pixel_type CORNER_PX [22] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h000001,
      24'h010000, 24'hFEFFFF, 24'h191A00, 24'h333333, 24'hCCCCCC, 24'h0A0A0A,
      24'hF4F4F4, 24'h141414, 24'h808080, 24'h7F7F7F, 24'h996633, 24'hFF00FF,
      24'h00FFFF, 24'hFFFF00, 24'hAA55AA, 24'h55AA55
   };

   class nearest_index_board_type;
      logic [RegWidth-1:0] base_reg [NumRegs];
      rgb_pixel_type       pending_px [$];
      logic [IdxWidth-1:0] pending_idx [$];
      int unsigned         fail_count;

      function new();
         foreach (base_reg[i]) base_reg[i] = '0;
         fail_count = 0;
      endfunction

      function void set_base(base_reg_type idx, logic [RegWidth-1:0] val);
         if (idx < NumRegs) base_reg[idx] = val;
      endfunction

      function logic [ChanWidth-1:0] table_byte(int unsigned k);
         return base_reg[k / 8][(k % 8) * 8 +: 8];
      endfunction

      function rgb_pixel_type entry_rgb(int unsigned idx);
         rgb_pixel_type c;
         int unsigned   cube_pos;
         int unsigned   v;
         if (idx < BaseCount) begin
            c.red   = table_byte(3 * idx);
            c.green = table_byte(3 * idx + 1);
            c.blue  = table_byte(3 * idx + 2);
         end else if (idx < GrayStart) begin
            cube_pos = idx - BaseCount;
            c.red    = 8'((cube_pos / 36) * 51);
            c.green  = 8'(((cube_pos / 6) % 6) * 51);
            c.blue   = 8'((cube_pos % 6) * 51);
         end else begin
            v = ((idx - GrayStart + 1) * 255) / 25;
            c = {8'(v), 8'(v), 8'(v)};
         end
         return c;
      endfunction

      function int unsigned chan_gap(logic [ChanWidth-1:0] a, logic [ChanWidth-1:0] b);
         return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
      endfunction

      // L1 distance over the whole palette, first minimum wins
      function logic [IdxWidth-1:0] nearest_entry(rgb_pixel_type px);
         int unsigned         best;
         int unsigned         d;
         logic [IdxWidth-1:0] best_idx;
         rgb_pixel_type       c;
         best     = 32'hFFFF_FFFF;
         best_idx = '0;
         for (int unsigned i = 0; i < NumEntries; i++) begin
            c = entry_rgb(i);
            d = chan_gap(px.red, c.red) + chan_gap(px.green, c.green)
                + chan_gap(px.blue, c.blue);
            if (d < best) begin
               best     = d;
               best_idx = 8'(i);
            end
         end
         return best_idx;
      endfunction

      function void note_pixel(rgb_pixel_type px);
         pending_px.push_back(px);
         pending_idx.push_back(nearest_entry(px));
      endfunction

      function void check_index(logic [IdxWidth-1:0] got);
         rgb_pixel_type       px;
         logic [IdxWidth-1:0] want;
         if (pending_idx.size() == 0) begin
            $display("%0t: palette_index expected none, got %0d", $time, got);
            fail_count++;
         end else begin
            px   = pending_px.pop_front();
            want = pending_idx.pop_front();
            if (got !== want) begin
               $display("%0t: palette_index for pixel %h expected %0d, got %0d",
                        $time, px, want, got);
               fail_count++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [RegIdxWidth-1:0] csr_index;
   logic [RegWidth-1:0]    csr_wdata;

   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;
   bit          hold_results   = 1'b0;
   int unsigned quiet_cycles   = 0;

   nearest_index_board_type board = new();

   ncp_req_if req_chan ();
   ncp_rsp_if rsp_chan ();

   nearest_color_256_palette_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_pixel({req_chan.red, req_chan.green, req_chan.blue});
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_index(rsp_chan.palette_index);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("nearest_color_256_palette_top: mismatch");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            rsp_chan.ready <= !(receiver_idles && $urandom_range(99) < 25);
         end
      end
   end

   task automatic send_pixel(input rgb_pixel_type px);
      while (sender_idles && $urandom_range(99) < 25) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.red   <= px.red;
      req_chan.green <= px.green;
      req_chan.blue  <= px.blue;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   function automatic logic [ChanWidth-1:0] nudge(logic [ChanWidth-1:0] v);
      int s;
      s = int'(v) + $urandom_range(6) - 3;
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return 8'(s);
   endfunction

   function automatic rgb_pixel_type pick_pixel();
      rgb_pixel_type        px;
      rgb_pixel_type        c;
      int unsigned          kind;
      logic [ChanWidth-1:0] lvl;
      kind = $urandom_range(99);
      if (kind < 40) begin
         px = rgb_pixel_type'(24'($urandom));
      end else if (kind < 65) begin
         c  = board.entry_rgb($urandom_range(NumEntries - 1));
         px = {nudge(c.red), nudge(c.green), nudge(c.blue)};
      end else if (kind < 80) begin
         lvl = 8'($urandom_range(255));
         px  = {nudge(lvl), nudge(lvl), nudge(lvl)};
      end else begin
         // halfway between cube levels, where ties land
         px.red   = 8'(51 * $urandom_range(4) + 25 + $urandom_range(1));
         px.green = 8'(51 * $urandom_range(4) + 25 + $urandom_range(1));
         px.blue  = 8'(51 * $urandom_range(4) + 25 + $urandom_range(1));
      end
      return px;
   endfunction

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(pick_pixel());
   endtask

   task automatic send_base_hits();
      for (int unsigned n = 0; n < BaseCount; n++) send_pixel(board.entry_rgb(n));
   endtask

   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (board.pending_idx.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input base_table_type vals, input bit poke_spare);
      for (int unsigned i = 0; i < NumRegs; i++) begin
         csr_we    <= 1'b1;
         csr_index <= base_reg_type'(i);
         csr_wdata <= vals[i];
         board.set_base(base_reg_type'(i), vals[i]);
         @(posedge clock);
      end
      if (poke_spare) begin
         csr_we    <= 1'b1;
         csr_index <= SPARE_REG_6;
         csr_wdata <= {$urandom, $urandom};
         board.set_base(SPARE_REG_6, '0);
         @(posedge clock);
         csr_index <= SPARE_REG_7;
         csr_wdata <= '1;
         board.set_base(SPARE_REG_7, '1);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      base_table_type regs;
      rgb_pixel_type  col;
      int unsigned    k;

      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.red   <= '0;
      req_chan.green <= '0;
      req_chan.blue  <= '0;
      csr_we         <= 1'b0;
      csr_index      <= BASE_REG_0;
      csr_wdata      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-black base table out of reset
      foreach (CORNER_PX[i]) send_pixel(CORNER_PX[i]);
      send_random(200);
      drain_pipeline();

      foreach (regs[i]) regs[i] = {$urandom, $urandom};
      write_regs(regs, 1'b1);
      send_base_hits();
      send_random(250);
      drain_pipeline();

      foreach (regs[i]) regs[i] = '1;
      write_regs(regs, 1'b0);
      send_pixel(24'hFFFFFF);
      send_random(150);
      drain_pipeline();

      foreach (regs[i]) regs[i] = '0;
      write_regs(regs, 1'b0);
      send_random(100);
      drain_pipeline();

      // base entries duplicating cube and gray colors: base index must win
      for (int unsigned n = 0; n < BaseCount; n++) begin
         col = board.entry_rgb(BaseCount + $urandom_range(NumEntries - BaseCount - 1));
         for (int unsigned c = 0; c < 3; c++) begin
            k = 3 * n + c;
            regs[k / 8][(k % 8) * 8 +: 8] = col[23 - 8 * c -: 8];
         end
      end
      write_regs(regs, 1'b0);
      send_base_hits();
      send_random(120);
      drain_pipeline();

      foreach (regs[i]) regs[i] = {$urandom, $urandom};
      write_regs(regs, 1'b1);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_random(200);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_results   = 1'b1;
      send_random(300);
      drain_pipeline();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.fail_count == 0)
         $display("nearest_color_256_palette_top: match");
      else
         $display("nearest_color_256_palette_top: mismatch");
      $finish;
   end

endmodule
